@@ rtl/bdq_pkg.sv @@
// bdq_pkg: opcode and status codes shared by the bounded double-ended queue
// no dependencies

package bdq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH_REAR  = 2'd0,
        OP_POP_REAR   = 2'd1,
        OP_PUSH_FRONT = 2'd2,
        OP_POP_FRONT  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

endpackage

@@ rtl/bdq_ram.sv @@
// bdq_ram: generic single-clock ram, one write port and one registered read port
// no dependencies

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/bounded_double_ended_queue.sv @@
// bounded_double_ended_queue: ring-buffer deque with entries held in bdq_ram
// depends on bdq_pkg and bdq_ram
//
// channel  dir  handshake           payload
// s_       in   s_valid / s_ready   s_opcode, s_push_value
// m_       out  m_valid / m_ready   m_status, m_pop_value, m_occupancy
//
// a push or a rejected operation has its result written straight to the output register;
// a successful pop first passes through the read state for the registered read of the entry ram
// result sits in an output register; a new transaction is taken only when that
// register is empty or is read in the same cycle, and never during a pop read
// synchronous active-low reset clears head, count and control; ram needs no clearing

module bounded_double_ended_queue
    import bdq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic signed [VALUE_BITS-1:0]        s_push_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic signed [VALUE_BITS-1:0]        m_pop_value,
    output logic [$clog2(CAPACITY+1)-1:0]       m_occupancy
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t                  state_reg;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    out_valid_reg;
    status_t                 status_reg, status_next;
    logic [VALUE_BITS-1:0]   pop_value_reg;
    logic [CNT_W-1:0]        occupancy_reg;

    opcode_t                 op;
    logic                    accept;
    logic                    is_full, is_empty;
    logic [SUM_W-1:0]        rear_sum, rear_last_sum;
    logic [IDX_W-1:0]        rear_pos, rear_last_pos;
    logic [IDX_W-1:0]        head_dec, head_inc;
    logic                    wr_en, rd_en;
    logic [IDX_W-1:0]        wr_addr, rd_addr;
    logic [VALUE_BITS-1:0]   rd_data;

    assign op       = opcode_t'(s_opcode);
    assign s_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    // ring position of rear slot and of last entry, one compare and subtract
    assign rear_sum      = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign rear_last_sum = rear_sum - SUM_W'(1);
    assign rear_pos      = (rear_sum >= SUM_W'(CAPACITY))
                           ? IDX_W'(rear_sum - SUM_W'(CAPACITY)) : IDX_W'(rear_sum);
    assign rear_last_pos = (rear_last_sum >= SUM_W'(CAPACITY))
                           ? IDX_W'(rear_last_sum - SUM_W'(CAPACITY))
                           : IDX_W'(rear_last_sum);
    assign head_dec = (head_reg == '0) ? IDX_W'(CAPACITY - 1) : head_reg - IDX_W'(1);
    assign head_inc = (head_reg == IDX_W'(CAPACITY - 1)) ? '0 : head_reg + IDX_W'(1);

    always_comb begin
        head_next   = head_reg;
        count_next  = count_reg;
        status_next = STAT_DONE;
        wr_en       = 1'b0;
        wr_addr     = rear_pos;
        rd_en       = 1'b0;
        rd_addr     = head_reg;
        case (op)
            OP_PUSH_REAR: begin
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    wr_en      = accept;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_FRONT: begin
                wr_addr = head_dec;
                if (is_full) begin
                    status_next = STAT_FULL;
                end else begin
                    wr_en      = accept;
                    head_next  = head_dec;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP_REAR: begin
                rd_addr = rear_last_pos;
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    rd_en      = accept;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (is_empty) begin
                    status_next = STAT_EMPTY;
                end else begin
                    rd_en      = accept;
                    head_next  = head_inc;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
                status_next = STAT_DONE;
            end
        endcase
    end

    bdq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        head_reg      <= head_next;
                        count_reg     <= count_next;
                        status_reg    <= status_next;
                        occupancy_reg <= count_next;
                        pop_value_reg <= '0;
                        out_valid_reg <= !rd_en;
                        if (rd_en) begin
                            state_reg <= ST_READ;
                        end
                    end else if (m_ready) begin
                        out_valid_reg <= 1'b0;
                    end
                end
                ST_READ: begin
                    pop_value_reg <= rd_data;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = status_reg;
    assign m_pop_value = pop_value_reg;
    assign m_occupancy = occupancy_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_read_completes: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_READ |=> m_valid && state_reg == ST_IDLE)
        else $error("pop read did not produce a result");

    a_full_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_FULL |-> m_occupancy == CNT_W'(CAPACITY))
        else $error("full status with spare room");

    a_empty_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STAT_EMPTY |-> m_occupancy == '0 && m_pop_value == '0)
        else $error("empty status with entries or a value");
`endif

endmodule

@@ dv/bounded_double_ended_queue_tb.sv @@
// bounded_double_ended_queue_tb: self-checking bench for the bounded deque, a directed
// table then push/pop bursts, results checked against pinned rows or a ring predictor
// depends on bdq_pkg and bounded_double_ended_queue

module bounded_double_ended_queue_tb;
    import bdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 16;
    localparam int WIDTH        = 32;
    localparam int OCC_BITS     = $clog2(DEPTH + 1);
    localparam int TABLE_ROWS   = 25;
    localparam int RANDOM_ITEMS = 425;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        status_t               status;
        logic [WIDTH-1:0]      value;
        logic [OCC_BITS-1:0]   occ;
    } deque_result_t;

    typedef struct packed {
        opcode_t               op;
        logic [WIDTH-1:0]      value;
        bit                    pinned;
        deque_result_t         result;
    } stim_row_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_opcode     = OP_PUSH_REAR;
    logic [WIDTH-1:0]      s_push_value = '0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [1:0]            m_status;
    logic [WIDTH-1:0]      m_pop_value;
    logic [OCC_BITS-1:0]   m_occupancy;

    logic [WIDTH-1:0]      ring [DEPTH];
    int                    head_pos;
    int                    held;

    deque_result_t         expected_results [$];
    stim_row_t             directed_rows [TABLE_ROWS];
    bit                    quiet;
    int                    sent_count;
    int                    checked_count;
    int                    pop_count;
    int                    full_count;
    int                    empty_count;
    int                    mismatches;
    int                    cycles;

    bounded_double_ended_queue #(
        .CAPACITY   (DEPTH),
        .VALUE_BITS (WIDTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_push_value (s_push_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_pop_value  (m_pop_value),
        .m_occupancy  (m_occupancy)
    );

    always #6 aclk = ~aclk;

    function automatic deque_result_t deque_step(input opcode_t op, input logic [WIDTH-1:0] value);
        deque_result_t r;
        r.status = STAT_DONE;
        r.value  = '0;
        case (op)
            OP_PUSH_REAR, OP_PUSH_FRONT: begin
                if (held >= DEPTH) begin
                    r.status = STAT_FULL;
                end else if (op == OP_PUSH_REAR) begin
                    ring[(head_pos + held) % DEPTH] = value;
                    held++;
                end else begin
                    head_pos       = (head_pos + DEPTH - 1) % DEPTH;
                    ring[head_pos] = value;
                    held++;
                end
            end
            default: begin
                if (held == 0) begin
                    r.status = STAT_EMPTY;
                end else if (op == OP_POP_REAR) begin
                    r.value = ring[(head_pos + held - 1) % DEPTH];
                    held--;
                end else begin
                    r.value  = ring[head_pos];
                    head_pos = (head_pos + 1) % DEPTH;
                    held--;
                end
            end
        endcase
        r.occ = OCC_BITS'(held);
        return r;
    endfunction

    function automatic logic [WIDTH-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_txn(input opcode_t op, input logic [WIDTH-1:0] value,
                            input bit pinned, input deque_result_t pinned_result);
        deque_result_t predicted;
        while (!quiet && $urandom_range(99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_opcode     <= op;
        s_push_value <= value;
        do @(posedge aclk); while (!s_ready);
        predicted = deque_step(op, value);
        expected_results.push_back(pinned ? pinned_result : predicted);
        case (predicted.status)
            STAT_FULL:  full_count++;
            STAT_EMPTY: empty_count++;
            default:    if (op inside {OP_POP_REAR, OP_POP_FRONT}) pop_count++;
        endcase
        sent_count++;
    endtask

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(99) >= 7);
    end

    always @(posedge aclk) begin
        deque_result_t want;
        if (aresetn && m_valid && m_ready) begin
            checked_count++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding: status %0d value %h occ %0d",
                                          m_status, m_pop_value, m_occupancy));
            end else begin
                want = expected_results.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %0d, wanted %0d", m_status, want.status));
                if (m_pop_value !== want.value)
                    report_mismatch($sformatf("pop_value %h, wanted %h", m_pop_value, want.value));
                if (m_occupancy !== want.occ)
                    report_mismatch($sformatf("occupancy %0d, wanted %0d", m_occupancy, want.occ));
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results outstanding", $realtime,
                     expected_results.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int burst_mode;
        int burst_len;
        int push_pct;
        bit is_push;
        bit at_front;
        bit drained_once;
        deque_result_t none;

        none         = '0;
        drained_once = 1'b0;
        head_pos     = 0;
        held         = 0;
        cycles       = 0;

        directed_rows = '{
            '{OP_POP_REAR,   32'hFFFF_FFFF, 1'b1, '{STAT_EMPTY, 32'h0000_0000, 5'd0}},
            '{OP_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{STAT_EMPTY, 32'h0000_0000, 5'd0}},
            '{OP_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, '{STAT_DONE,  32'h0000_0000, 5'd1}},
            '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{STAT_DONE,  32'h0000_0000, 5'd2}},
            '{OP_POP_REAR,   32'h0000_0000, 1'b1, '{STAT_DONE,  32'h7FFF_FFFF, 5'd1}},
            '{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{STAT_DONE,  32'h8000_0000, 5'd0}},
            '{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
            '{OP_PUSH_REAR,  32'hFFFF_FFFE, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'hA5A5_A5A5, 1'b0, '0},
            '{OP_PUSH_REAR,  32'h5A5A_5A5A, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_PUSH_REAR,  32'h0000_0000, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'h1234_5678, 1'b0, '0},
            '{OP_PUSH_REAR,  32'h8765_4321, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'h0F0F_0F0F, 1'b0, '0},
            '{OP_PUSH_REAR,  32'hF0F0_F0F0, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'h8000_0001, 1'b0, '0},
            '{OP_PUSH_REAR,  32'h7FFF_FFFE, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, '0},
            '{OP_PUSH_REAR,  32'hCAFE_F00D, 1'b0, '0},
            '{OP_PUSH_FRONT, 32'h0000_FFFF, 1'b0, '0},
            '{OP_PUSH_REAR,  32'hFFFF_0000, 1'b0, '0},
            '{OP_PUSH_REAR,  32'h1111_1111, 1'b1, '{STAT_FULL,  32'h0000_0000, 5'd16}},
            '{OP_PUSH_FRONT, 32'h2222_2222, 1'b1, '{STAT_FULL,  32'h0000_0000, 5'd16}},
            '{OP_POP_FRONT,  32'h0000_0000, 1'b0, '0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_txn(directed_rows[i].op, directed_rows[i].value,
                     directed_rows[i].pinned, directed_rows[i].result);

        while (sent_count < TABLE_ROWS + RANDOM_ITEMS) begin
            if (!drained_once && sent_count >= 200) begin
                s_valid <= 1'b0;
                while (expected_results.size() != 0) @(posedge aclk);
                drained_once = 1'b1;
            end
            burst_mode = $urandom_range(2);
            burst_len  = $urandom_range(8, 40);
            push_pct   = (burst_mode == 0) ? 80 : (burst_mode == 1) ? 20 : 50;
            for (int i = 0; i < burst_len && sent_count < TABLE_ROWS + RANDOM_ITEMS; i++) begin
                quiet    = (sent_count >= 260 && sent_count < 360);
                is_push  = ($urandom_range(99) < push_pct);
                at_front = $urandom_range(1);
                send_txn(opcode_t'({at_front, !is_push}), pick_value(), 1'b0, none);
            end
        end
        quiet    = 1'b0;
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d transactions sent, %0d results checked", sent_count, checked_count);
        $display("successful pops %0d, full rejects %0d, empty rejects %0d, mismatches %0d",
                 pop_count, full_count, empty_count, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
